// ===== design/sspd_pkg.sv =====
// sspd_pkg: shared types and constants of the shared solenoid pulse driver
// holds the request/response payload structs, kind codes and queue entry type
// no dependencies
package sspd_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int NUM_COILS   = 32;

   localparam logic [7:0] STROBE_RESET = 8'h01;

   localparam logic [2:0] KIND_REQUEST     = 3'd0;
   localparam logic [2:0] KIND_TICK        = 3'd1;
   localparam logic [2:0] KIND_DISPATCH    = 3'd2;
   localparam logic [2:0] KIND_MOD_DUTY    = 3'd3;
   localparam logic [2:0] KIND_MOD_TIMEOUT = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] coil;
      logic [7:0] duty_bits;
      logic [7:0] time_ms;
      logic       invert;
   } req_type;

   typedef struct packed {
      logic       drive_write;
      logic [4:0] drive_coil;
      logic       drive_level;
      logic       pulse_done;
      logic       started;
      logic       dropped;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [4:0] coil;
      logic [7:0] duty;
      logic [7:0] time_ms;
      logic       invert;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   // pulse length in ticks of 4 ms
   function automatic logic [5:0] ms_to_ticks(input logic [7:0] time_ms);
      return time_ms[7:2];
   endfunction

endpackage

// ===== design/sspd_chan_if.sv =====
// sspd_chan_if: valid/ready channel carrying one payload per transfer
// payload type is set per instance; used with sspd_pkg::req_type and rsp_type
// no dependencies
interface sspd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sspd_ram.sv =====
// sspd_ram: generic single write port, single read port ram with registered read
// read returns the old contents when the same address is written in that cycle
// no dependencies
module sspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/shared_solenoid_pulse_driver.sv =====
// shared_solenoid_pulse_driver: one-at-a-time coil pulse driver with request queue
// depends on sspd_pkg, sspd_chan_if and sspd_ram
//
// usage
//   req_ch carries one item per transfer: a request, a 4 ms tick, a dispatch
//   poll, or a duty / timeout modify. every item yields exactly one response
//   on rsp_ch, in order.
//   requests that arrive while a pulse runs wait in a queue of QUEUE_DEPTH
//   entries held in a ram; a full queue drops the request and flags it.
//   a dispatch poll starts the oldest queued request when no pulse runs.
//   the response is registered and waits in the output buffer while rsp_ch stalls.
//   throughput: one item per cycle while req_ch.ready is high, set by the single
//   state update per cycle and the one ram read of the queue head, which is
//   fetched ahead and forwarded when written in the same cycle.
//   a two-entry output buffer keeps req_ch.ready high while one response
//   waits; ready drops only when both entries are full.
//   reset clears the pulse state, the strobe to bit 0 and the queue pointers;
//   queue contents are not cleared and need no clearing pass.
module shared_solenoid_pulse_driver #(
   parameter int QUEUE_DEPTH = sspd_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   sspd_chan_if.sink    req_ch,
   sspd_chan_if.source  rsp_ch
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   sspd_pkg::req_type   req;
   sspd_pkg::rsp_type   rsp_new;
   sspd_pkg::entry_type new_entry;
   sspd_pkg::entry_type head_entry;
   logic [sspd_pkg::ENTRY_WIDTH-1:0] ram_rd_data;

   logic [5:0]       ticks_ff, ticks_in;
   logic [7:0]       duty_ff, duty_in;
   logic [4:0]       coil_ff, coil_in;
   logic             invert_ff, invert_in;
   logic [7:0]       strobe_ff, strobe_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                fwd_valid_ff;
   sspd_pkg::entry_type fwd_data_ff;

   logic                out_valid_ff, skid_valid_ff;
   sspd_pkg::rsp_type   out_data_ff, skid_data_ff;

   logic       accept, pop;
   logic       wr_en;
   logic [5:0] ticks_dec;
   logic       coil_ok;

   assign req     = req_ch.payload;
   assign accept  = req_ch.valid && req_ch.ready;
   assign pop     = out_valid_ff && rsp_ch.ready;
   assign coil_ok = 32'(req.coil) < sspd_pkg::NUM_COILS;

   assign new_entry.coil    = req.coil;
   assign new_entry.duty    = req.duty_bits;
   assign new_entry.time_ms = req.time_ms;
   assign new_entry.invert  = req.invert;

   assign head_entry = fwd_valid_ff ? fwd_data_ff : sspd_pkg::entry_type'(ram_rd_data);
   assign ticks_dec  = ticks_ff - 6'd1;

   // pulse and queue state update, and the response for each item
   always_comb begin
      ticks_in  = ticks_ff;
      duty_in   = duty_ff;
      coil_in   = coil_ff;
      invert_in = invert_ff;
      strobe_in = strobe_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rsp_new   = '0;
      if (accept) begin
         case (req.kind)
            sspd_pkg::KIND_REQUEST: begin
               if (coil_ok) begin
                  if (ticks_ff == 6'd0) begin
                     coil_in         = req.coil;
                     duty_in         = req.duty_bits;
                     invert_in       = req.invert;
                     ticks_in        = sspd_pkg::ms_to_ticks(req.time_ms);
                     rsp_new.started = 1'b1;
                  end else if (count_ff != CNT_FULL) begin
                     wr_en    = 1'b1;
                     tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     rsp_new.dropped = 1'b1;
                  end
               end
            end
            sspd_pkg::KIND_TICK: begin
               if (ticks_ff != 6'd0) begin
                  ticks_in            = ticks_dec;
                  rsp_new.drive_write = 1'b1;
                  rsp_new.drive_coil  = coil_ff;
                  rsp_new.drive_level = ((ticks_dec != 6'd0) && ((duty_ff & strobe_ff) != 8'd0))
                                        ^ invert_ff;
                  if (ticks_dec == 6'd0) begin
                     duty_in            = 8'd0;
                     rsp_new.pulse_done = 1'b1;
                  end
               end
               strobe_in = {strobe_ff[6:0], strobe_ff[7]};
            end
            sspd_pkg::KIND_DISPATCH: begin
               if (ticks_ff == 6'd0 && count_ff != '0) begin
                  head_in         = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
                  count_in        = count_ff - 1'b1;
                  coil_in         = head_entry.coil;
                  duty_in         = head_entry.duty;
                  invert_in       = head_entry.invert;
                  ticks_in        = sspd_pkg::ms_to_ticks(head_entry.time_ms);
                  rsp_new.started = 1'b1;
               end
            end
            sspd_pkg::KIND_MOD_DUTY: begin
               duty_in = req.duty_bits;
            end
            sspd_pkg::KIND_MOD_TIMEOUT: begin
               ticks_in = sspd_pkg::ms_to_ticks(req.time_ms);
            end
            default: begin
            end
         endcase
      end
      rsp_new.busy_res = ticks_in != 6'd0;
   end

   sspd_ram #(
      .WIDTH (sspd_pkg::ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (new_entry),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= '0;
         duty_ff      <= '0;
         coil_ff      <= '0;
         invert_ff    <= 1'b0;
         strobe_ff    <= sspd_pkg::STROBE_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         ticks_ff     <= ticks_in;
         duty_ff      <= duty_in;
         coil_ff      <= coil_in;
         invert_ff    <= invert_in;
         strobe_ff    <= strobe_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         // head entry written this cycle: ram read returns the old data
         fwd_valid_ff <= wr_en && (tail_ff == head_in);
      end
      fwd_data_ff <= new_entry;
   end

   // two-entry output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff) begin
            out_valid_ff <= accept;
         end else if (pop) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= accept;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
      if (!out_valid_ff || (pop && !skid_valid_ff)) begin
         out_data_ff <= rsp_new;
      end else if (pop) begin
         out_data_ff  <= skid_data_ff;
         skid_data_ff <= rsp_new;
      end else if (accept) begin
         skid_data_ff <= rsp_new;
      end
   end

   assign req_ch.ready   = !skid_valid_ff;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_done_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.pulse_done) |->
         (rsp_ch.payload.drive_write && !rsp_ch.payload.busy_res))
      else $error("pulse done without a final coil write");

   a_strobe_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(strobe_ff))
      else $error("strobe lost its single bit");
`endif

endmodule
